/* rtl/trle_pkg.sv */
// Shared types, constants and a helper function for the TGA run-length packet decoder.
`timescale 1ns / 1ps

package trle_pkg;

    // Field and register widths.
    localparam int BYTE_W      = 8;
    localparam int PIXEL_W     = 32;
    localparam int ASM_W       = 24;
    localparam int COUNT_W     = 8;
    localparam int BPP_W       = 3;
    localparam int PIX_COUNT_W = 32;
    localparam int POS_W       = 2;

    // Largest supported pixel size in bytes.
    localparam logic [BPP_W-1:0] MAX_BPP = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_BPP       = 1'b0;
    localparam logic CFG_PIX_COUNT = 1'b1;

    // Configuration reset values.
    localparam logic [BPP_W-1:0]       BPP_RESET       = 3'd3;
    localparam logic [PIX_COUNT_W-1:0] PIX_COUNT_RESET = 32'd1;

    // One decoded pixel handed from the front end to the back end.
    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               is_run;
        logic               packet_end;
    } pix_event_t;

    // Effective pixel size: zero acts as one, large values clip to the maximum.
    function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] bpp);
        logic [BPP_W-1:0] b;
        begin
            b = bpp;
            if (b == '0)
            begin
                b = 3'd1;
            end
            if (b > MAX_BPP)
            begin
                b = MAX_BPP;
            end
            return b;
        end
    endfunction

endpackage

/* rtl/trle_front.sv */
// Front end: parses packet headers and gathers stream bytes into pixels.
`timescale 1ns / 1ps

module trle_front
    import trle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_accept,
    input  logic [BYTE_W-1:0]      stream_byte,
    input  logic [BPP_W-1:0]       bytes_per_pixel,
    output logic                   ev_push,
    output pix_event_t             ev_data
);

    localparam logic PH_HEADER = 1'b0;
    localparam logic PH_PIXEL  = 1'b1;

    logic               phase_reg, phase_next;
    logic               run_reg, run_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ASM_W-1:0]   asm_reg, asm_next;

    logic [PIXEL_W-1:0] merged;
    logic [BPP_W-1:0]   bpp_eff;
    logic               last_byte;
    logic [COUNT_W-1:0] left_after;

    // Place the incoming byte at its position in the pixel being gathered.
    always_comb
    begin
        merged = {8'h00, asm_reg};
        merged[{pos_reg, 3'b000} +: BYTE_W] = stream_byte;
    end

    assign bpp_eff    = eff_bpp(bytes_per_pixel);
    assign last_byte  = ({1'b0, pos_reg} + 3'd1) >= bpp_eff;
    assign left_after = run_reg ? '0 : left_reg - 8'd1;

    // Header parsing, byte gathering and pixel emission.
    always_comb
    begin
        phase_next      = phase_reg;
        run_next        = run_reg;
        left_next       = left_reg;
        pos_next        = pos_reg;
        asm_next        = asm_reg;
        ev_push         = 1'b0;
        ev_data.value   = merged;
        ev_data.count   = run_reg ? left_reg : 8'd1;
        ev_data.is_run  = run_reg;
        ev_data.packet_end = (left_after == '0);

        if (byte_accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    // Raw packets hold header+1 pixels and runs header-127 copies;
                    // both come to the low seven bits plus one.
                    run_next   = stream_byte[7];
                    left_next  = {1'b0, stream_byte[6:0]} + 8'd1;
                    pos_next   = '0;
                    asm_next   = '0;
                    phase_next = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    if (!last_byte)
                    begin
                        asm_next = merged[ASM_W-1:0];
                        pos_next = pos_reg + 2'd1;
                    end
                    else
                    begin
                        ev_push   = 1'b1;
                        pos_next  = '0;
                        asm_next  = '0;
                        left_next = left_after;
                        if (left_after == '0)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            run_reg   <= 1'b0;
            left_reg  <= '0;
            pos_reg   <= '0;
            asm_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            run_reg   <= run_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            asm_reg   <= asm_next;
        end
    end

endmodule

/* rtl/trle_fifo.sv */
// Two-entry queue of decoded pixels between the front end and the back end.
`timescale 1ns / 1ps

module trle_fifo
    import trle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pix_event_t push_data,
    output logic       full,
    input  logic       pop,
    output pix_event_t pop_data,
    output logic       empty
);

    pix_event_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/trle_back.sv */
// Back end: counts pixels against the image size and drives the result register.
`timescale 1ns / 1ps

module trle_back
    import trle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [PIX_COUNT_W-1:0] pixel_count,
    input  logic                   ev_empty,
    input  pix_event_t             ev_data,
    output logic                   ev_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PIXEL_W-1:0]     pixel_value,
    output logic [COUNT_W-1:0]     repeat_count,
    output logic                   image_done,
    output logic                   overrun_error
);

    logic                   out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]     value_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   done_reg;
    logic                   err_reg;
    logic                   halted_reg, halted_next;
    logic [PIX_COUNT_W-1:0] decoded_reg, decoded_next;

    logic                   can_load;
    logic                   process;
    logic [PIX_COUNT_W:0]   diff;
    logic [PIX_COUNT_W-1:0] count_ext;
    logic                   overrun;
    logic                   done;
    logic [COUNT_W-1:0]     count_out;

    // Once halted the queue is drained and every entry dropped.
    assign can_load = !out_valid_reg || out_ready;
    assign ev_pop   = !ev_empty && (halted_reg || can_load);
    assign process  = ev_pop && !halted_reg;

    // Pixels left in the image; a borrow means none are left.
    assign diff      = {1'b0, pixel_count} - {1'b0, decoded_reg};
    assign count_ext = {{(PIX_COUNT_W-COUNT_W){1'b0}}, ev_data.count};
    assign overrun   = diff[PIX_COUNT_W] || (count_ext > diff[PIX_COUNT_W-1:0]);
    assign done      = !overrun && (count_ext == diff[PIX_COUNT_W-1:0]);

    // On overrun a run is clipped to the pixels left and a literal gets zero.
    always_comb
    begin
        if (!overrun)
        begin
            count_out = ev_data.count;
        end
        else if (ev_data.is_run && !diff[PIX_COUNT_W])
        begin
            count_out = diff[COUNT_W-1:0];
        end
        else
        begin
            count_out = '0;
        end
    end

    // Pixel counter, halt flag and output handshake.
    always_comb
    begin
        decoded_next   = decoded_reg;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (process)
        begin
            out_valid_next = 1'b1;
            if (overrun)
            begin
                halted_next = 1'b1;
            end
            else if (done && ev_data.packet_end)
            begin
                decoded_next = '0;
            end
            else
            begin
                decoded_next = decoded_reg + count_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            halted_reg    <= 1'b0;
            decoded_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            halted_reg    <= halted_next;
            decoded_reg   <= decoded_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            value_reg <= ev_data.value;
            count_reg <= count_out;
            done_reg  <= done;
            err_reg   <= overrun;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_value   = value_reg;
    assign repeat_count  = count_reg;
    assign image_done    = done_reg;
    assign overrun_error = err_reg;

endmodule

/* rtl/tga_rle_packet_decoder.sv */
// Top level of the TGA run-length packet decoder with its configuration registers.
`timescale 1ns / 1ps
//
// Usage:
// - Input channel (in_valid/in_ready/stream_byte) takes one byte of the compressed
//   packet stream per transaction: header bytes and pixel bytes in stream order.
// - Output channel (out_valid/out_ready) delivers one transaction per decoded pixel:
//   pixel_value, repeat_count, image_done on the last pixel of the image and
//   overrun_error when a packet runs past the image size.
// - Configuration is written through cfg_we/cfg_index/cfg_data while idle:
//   index 0 is bytes per pixel (reset 3), index 1 is the pixel count (reset 1).
// - Throughput is one byte per cycle while the queue is not full. The edge that
//   accepts the byte completing its pixel writes the queue entry, and the entry
//   loads the result register once that register is free to load.
// - A two-entry queue sits between the front end and the back end. When the
//   receiver stalls the queue fills and in_ready drops once it is full.
// - After an overrun result the block keeps accepting bytes but drops them, and
//   gives no further results until reset.
// - Reset clears the parser and the pixel counter and returns the configuration
//   registers to their reset values.
//
module tga_rle_packet_decoder
    import trle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      stream_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PIXEL_W-1:0]     pixel_value,
    output logic [COUNT_W-1:0]     repeat_count,
    output logic                   image_done,
    output logic                   overrun_error,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [PIX_COUNT_W-1:0] cfg_data
);

    logic [BPP_W-1:0]       bpp_reg;
    logic [PIX_COUNT_W-1:0] pix_count_reg;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    pix_event_t q_in;
    pix_event_t q_out;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg       <= BPP_RESET;
            pix_count_reg <= PIX_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BPP:       bpp_reg       <= cfg_data[BPP_W-1:0];
                CFG_PIX_COUNT: pix_count_reg <= cfg_data;
                default:       bpp_reg       <= bpp_reg;
            endcase
        end
    end

    assign in_ready = !q_full;

    trle_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_accept     (in_valid && in_ready),
        .stream_byte     (stream_byte),
        .bytes_per_pixel (bpp_reg),
        .ev_push         (q_push),
        .ev_data         (q_in)
    );

    trle_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    trle_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_count   (pix_count_reg),
        .ev_empty      (q_empty),
        .ev_data       (q_out),
        .ev_pop        (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_value   (pixel_value),
        .repeat_count  (repeat_count),
        .image_done    (image_done),
        .overrun_error (overrun_error)
    );

    // A result never marks both image completion and an overrun.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(image_done && overrun_error))
        else $error("image_done and overrun_error set together");

    // Only an overrun can report a zero repeat count, and no count exceeds a full run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overrun_error |-> (repeat_count != '0) && (repeat_count <= 8'd128))
        else $error("repeat_count out of range on a normal result");

    // After an overrun result is taken the block stays silent.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && overrun_error |=> !out_valid)
        else $error("result produced after overrun");

    // The queue is never pushed while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("pixel queue overflow");

endmodule

/* dv/tga_rle_packet_decoder_checker.sv */
`timescale 1ns / 1ps
// Checker for the TGA run-length packet decoder: watches both channels, predicts pixels, compares.
module tga_rle_packet_decoder_checker
    import trle_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [BYTE_W-1:0]      stream_byte,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [PIXEL_W-1:0]     pixel_value,
    input  logic [COUNT_W-1:0]     repeat_count,
    input  logic                   image_done,
    input  logic                   overrun_error,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [PIX_COUNT_W-1:0] cfg_data,
    output int                     pending,
    output int                     fail_count
);

    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_GATHER,
        DEC_HALTED
    } decode_phase_t;

    // One predicted output transaction.
    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               done;
        logic               overrun;
    } pixel_result_t;

    // Shadow copy of the configuration registers.
    logic [BPP_W-1:0]       bpp_reg         = BPP_RESET;
    logic [PIX_COUNT_W-1:0] pixel_count_reg = PIX_COUNT_RESET;

    // Decoder state as the predictor sees it.
    decode_phase_t          phase              = DEC_HEADER;
    logic                   run_packet         = 1'b0;
    logic [COUNT_W-1:0]     packet_pixels_left = '0;
    logic [POS_W-1:0]       byte_pos           = '0;
    logic [ASM_W-1:0]       assembly           = '0;
    logic [PIX_COUNT_W-1:0] image_pixels       = '0;

    pixel_result_t expected_pixels[$];
    pixel_result_t oldest;
    int            outstanding = 0;
    int            mismatches  = 0;

    assign pending    = outstanding;
    assign fail_count = mismatches;

    // Bytes that make one pixel: zero acts as one, large values clip.
    function automatic int pixel_bytes(input logic [BPP_W-1:0] bpp);
        if (bpp == '0)
        begin
            return 1;
        end
        if (bpp > MAX_BPP)
        begin
            return int'(MAX_BPP);
        end
        return int'(bpp);
    endfunction

    // Advance the predicted decoder by one stream byte and queue any pixel it completes.
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [PIXEL_W-1:0]     value;
        logic [PIX_COUNT_W-1:0] remaining;
        logic [PIX_COUNT_W-1:0] count;
        pixel_result_t          r;
        if (phase == DEC_HALTED)
        begin
            return;
        end
        // A header opens a literal packet below 128 and a run packet otherwise.
        if (phase == DEC_HEADER)
        begin
            run_packet         = b[7];
            packet_pixels_left = b[7] ? b - 8'd127 : b + 8'd1;
            byte_pos           = '0;
            assembly           = '0;
            phase              = DEC_GATHER;
            return;
        end
        // Gather bytes until the pixel is complete.
        if (int'(byte_pos) + 1 < pixel_bytes(bpp_reg))
        begin
            assembly = assembly | (ASM_W'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 1'b1;
            return;
        end
        value    = PIXEL_W'(assembly) | (PIXEL_W'(b) << (8 * byte_pos));
        byte_pos = '0;
        assembly = '0;

        remaining = (image_pixels >= pixel_count_reg) ? '0 : pixel_count_reg - image_pixels;
        count     = run_packet ? PIX_COUNT_W'(packet_pixels_left) : PIX_COUNT_W'(1);
        r.value   = value;
        r.done    = 1'b0;

        // The packet runs past the image: report it and stop decoding.
        if (count > remaining)
        begin
            r.count   = run_packet ? remaining[COUNT_W-1:0] : '0;
            r.overrun = 1'b1;
            phase     = DEC_HALTED;
            expected_pixels.push_back(r);
            return;
        end
        r.count      = count[COUNT_W-1:0];
        r.overrun    = 1'b0;
        image_pixels = image_pixels + count;

        packet_pixels_left = run_packet ? '0 : packet_pixels_left - 1'b1;
        if (packet_pixels_left == '0)
        begin
            phase = DEC_HEADER;
        end
        // The image restarts only when its last pixel also closes the packet.
        if (image_pixels == pixel_count_reg)
        begin
            r.done = 1'b1;
            if (packet_pixels_left == '0)
            begin
                image_pixels = '0;
            end
        end
        expected_pixels.push_back(r);
    endtask

    // Compare results, track configuration writes and predict from accepted bytes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg            = BPP_RESET;
            pixel_count_reg    = PIX_COUNT_RESET;
            phase              = DEC_HEADER;
            run_packet         = 1'b0;
            packet_pixels_left = '0;
            byte_pos           = '0;
            assembly           = '0;
            image_pixels       = '0;
            expected_pixels.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected output transaction: pixel_value %0h", pixel_value);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    if (pixel_value !== oldest.value)
                    begin
                        $error("pixel_value: expected %0h, actual %0h", oldest.value,
                               pixel_value);
                        mismatches++;
                    end
                    if (repeat_count !== oldest.count)
                    begin
                        $error("repeat_count: expected %0d, actual %0d", oldest.count,
                               repeat_count);
                        mismatches++;
                    end
                    if (image_done !== oldest.done)
                    begin
                        $error("image_done: expected %0b, actual %0b", oldest.done,
                               image_done);
                        mismatches++;
                    end
                    if (overrun_error !== oldest.overrun)
                    begin
                        $error("overrun_error: expected %0b, actual %0b", oldest.overrun,
                               overrun_error);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_BPP)
                begin
                    bpp_reg = cfg_data[BPP_W-1:0];
                end
                else
                begin
                    pixel_count_reg = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                decode_byte(stream_byte);
            end
        end
        outstanding = expected_pixels.size();
    end

endmodule

/* dv/tga_rle_packet_decoder_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the TGA run-length packet decoder: clock, reset, stimulus and verdict.
module tga_rle_packet_decoder_tb;
    import trle_pkg::*;

    localparam int RANDOM_BYTES = 950;
    localparam int IDLE_PERCENT = 38;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [PIX_COUNT_W-1:0] PIX_COUNT_MAX = 32'd4294836225;

    // Ways the run is brought to its final overrun.
    typedef enum int {
        END_RUN_OVERRUN,
        END_LITERAL_OVERRUN,
        END_ZERO_COUNT
    } overrun_case_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [BYTE_W-1:0]      stream_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [PIXEL_W-1:0]     pixel_value;
    logic [COUNT_W-1:0]     repeat_count;
    logic                   image_done;
    logic                   overrun_error;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [PIX_COUNT_W-1:0] cfg_data;

    logic                   calm;
    logic [BPP_W-1:0]       cur_bpp;
    int                     pending;
    int                     fail_count;
    int                     cycle_count = 0;
    int                     random_bytes;

    tga_rle_packet_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stream_byte   (stream_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_value   (pixel_value),
        .repeat_count  (repeat_count),
        .image_done    (image_done),
        .overrun_error (overrun_error),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tga_rle_packet_decoder_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stream_byte   (stream_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_value   (pixel_value),
        .repeat_count  (repeat_count),
        .image_done    (image_done),
        .overrun_error (overrun_error),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // The receiver stalls at random except during the calm stretch.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Bytes that make one pixel for a register value.
    function automatic int pixel_bytes(input logic [BPP_W-1:0] bpp);
        if (bpp == '0)
        begin
            return 1;
        end
        if (bpp > MAX_BPP)
        begin
            return int'(MAX_BPP);
        end
        return int'(bpp);
    endfunction

    // Offer one stream byte after a random idle gap and wait for its transaction.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        while (!calm && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        random_bytes++;
    endtask

    // Write a register once all results are out and the pipeline has drained.
    task automatic write_cfg(input logic idx, input logic [PIX_COUNT_W-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BPP)
        begin
            cur_bpp = data[BPP_W-1:0];
        end
    endtask

    // Any pixel size from 0 to 7, with random upper bits in the write data.
    task automatic write_bpp_random();
        logic [PIX_COUNT_W-1:0] data;
        data        = $urandom();
        data[2:0]   = $urandom_range(0, 7);
        write_cfg(CFG_BPP, data);
    endtask

    // One pixel of random bytes; now and then the pixel size changes partway through.
    task automatic send_pixel();
        int sent;
        sent = 0;
        forever
        begin
            send_byte(BYTE_W'($urandom()));
            sent++;
            if (sent >= pixel_bytes(cur_bpp))
            begin
                break;
            end
            if ($urandom_range(0, 99) < 3)
            begin
                write_bpp_random();
            end
        end
    endtask

    // Packets of random kind and length that add up to exactly the given pixels.
    task automatic send_packets(input int unsigned pixels);
        int unsigned left;
        int unsigned len;
        int unsigned cap;
        bit          is_run;
        left = pixels;
        while (left > 0)
        begin
            cap = ($urandom_range(0, 99) < 20) ? 128 : 8;
            if (cap > left)
            begin
                cap = left;
            end
            len    = $urandom_range(1, cap);
            is_run = $urandom_range(0, 1);
            if (is_run)
            begin
                send_byte(BYTE_W'(len + 127));
                send_pixel();
            end
            else
            begin
                send_byte(BYTE_W'(len - 1));
                repeat (len) send_pixel();
            end
            left -= len;
        end
    endtask

    // Main stimulus.
    initial
    begin
        int unsigned   n;
        int unsigned   k;
        int unsigned   len;
        int unsigned   mode;
        overrun_case_t ending;

        in_valid     = 1'b0;
        stream_byte  = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_BPP;
        cfg_data     = '0;
        calm         = 1'b0;
        cur_bpp      = BPP_RESET;
        random_bytes = 0;
        rst_n        = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: one literal pixel of three bytes completes the image.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hAA);
        // A run of one under the same settings.
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        // Four-byte pixels, all ones then all zeros.
        write_cfg(CFG_BPP, 32'hFFFF_FFFC);
        write_cfg(CFG_PIX_COUNT, 32'd2);
        send_byte(8'h01);
        repeat (4) send_byte(8'hFF);
        repeat (4) send_byte(8'h00);
        // A pixel size of zero acts as one byte; two runs of the longest length.
        write_cfg(CFG_BPP, 32'd0);
        write_cfg(CFG_PIX_COUNT, 32'd256);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(8'hA5);

        // Random images of well-formed packets, with a calm stretch in the middle.
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            calm = (random_bytes >= 350) && (random_bytes < 500);
            if ($urandom_range(0, 99) < 40)
            begin
                write_bpp_random();
            end
            mode = $urandom_range(0, 99);
            if (mode < 86)
            begin
                n = $urandom_range(1, 24);
                write_cfg(CFG_PIX_COUNT, n);
                send_packets(n);
            end
            else if (mode < 92)
            begin
                n = $urandom_range(100, 200);
                write_cfg(CFG_PIX_COUNT, n);
                send_packets(n);
            end
            else
            begin
                // Start under a huge pixel count, then lower it to close the image.
                n = $urandom_range(1, 16);
                write_cfg(CFG_PIX_COUNT, $urandom_range(0, 1) ? PIX_COUNT_MAX
                                                              : ($urandom() | 32'h8000_0000));
                send_packets(n);
                k = $urandom_range(1, 16);
                write_cfg(CFG_PIX_COUNT, n + k);
                send_packets(k);
            end
        end
        calm = 1'b0;

        // The overrun halts the block for good, so it comes last.
        ending = overrun_case_t'($urandom_range(0, 2));
        k      = $urandom_range(1, 20);
        case (ending)
            END_RUN_OVERRUN:
            begin
                write_cfg(CFG_PIX_COUNT, k);
                len = $urandom_range(k + 1, 128);
                send_byte(BYTE_W'(len + 127));
                send_pixel();
            end
            END_LITERAL_OVERRUN:
            begin
                write_cfg(CFG_PIX_COUNT, k);
                len = k + $urandom_range(1, 8);
                send_byte(BYTE_W'(len - 1));
                repeat (k + 1) send_pixel();
            end
            default:
            begin
                write_cfg(CFG_PIX_COUNT, 32'd0);
                send_packets($urandom_range(1, 4));
            end
        endcase
        // Bytes after the overrun are taken and dropped.
        repeat ($urandom_range(4, 12)) send_byte(BYTE_W'($urandom()));

        // Let every expected result arrive, then watch a little longer.
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (2 * DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
